[hdl/dwc_pkg.sv]
// ----------------------------------------------------------------------------
// dwc_pkg: shared constants and types for the 7x7 depthwise convolution
// widths, operation and register codes, controller command bundle
// ----------------------------------------------------------------------------
package dwc_pkg;

   // kernel geometry
   localparam int KSIZE = 7;
   localparam int KPAD  = 3;
   localparam int KTAPS = KSIZE * KSIZE;

   // pixel store geometry (row and col ports are 6 bits wide)
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_WIDTH  = 64;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int PIX_DEPTH  = MAX_HEIGHT * MAX_WIDTH;
   localparam int PIX_AW     = $clog2(PIX_DEPTH);

   localparam int KIDX_W  = $clog2(KSIZE);
   localparam int TAP_W   = $clog2(KTAPS);
   localparam int DATA_W  = 8;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int ACC_W   = 32;
   localparam int DIM_W   = 7;
   localparam int SHIFT_W = 5;
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 7;

   localparam int SAT_HI = 127;
   localparam int SAT_LO = -128;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_BIAS   = 2'd1;
   localparam logic [OP_W-1:0] OP_STORE_PIXEL = 2'd2;
   localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ENABLE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SHIFT = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic              accept;    // request beat taken this cycle
      logic              start;     // latch query position, preload bias
      logic              issue;     // read one tap
      logic [KIDX_W-1:0] kr;
      logic [KIDX_W-1:0] kc;
      logic [TAP_W-1:0]  tap;
      logic              shift_en;  // register shifted sum
      logic              out_load;  // load output register
   } dwc_cmd_type;

endpackage

[hdl/depthwise_conv7x7_int8.sv]
// ----------------------------------------------------------------------------
// depthwise_conv7x7_int8: one channel of a 7x7 depthwise convolution
// loads weights, bias and pixels, answers single-position output queries
// ----------------------------------------------------------------------------
// loads (weight, bias, pixel) take one beat each, one per cycle while idle
// a compute beat makes 49 tap reads, one per cycle through the single-port
// pixel and weight rams, then drain, shift and saturate; the result waits
// for a free response slot; the next beat is taken once the result is loaded
// synchronous active-high reset clears control and the registers to
// 64 x 64, no relu, no shift; ram contents stay undefined until written
module depthwise_conv7x7_int8 (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dwc_pkg::OP_W-1:0]              req_operation,
   input  logic [dwc_pkg::ROW_W-1:0]             req_row,
   input  logic [dwc_pkg::COL_W-1:0]             req_col,
   input  logic signed [dwc_pkg::DATA_W-1:0]     req_sample,
   input  logic signed [dwc_pkg::ACC_W-1:0]      req_bias_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dwc_pkg::DATA_W-1:0]     rsp_out_pixel,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dwc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dwc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   logic [dwc_pkg::DIM_W-1:0]   plane_height_ff;
   logic [dwc_pkg::DIM_W-1:0]   plane_width_ff;
   logic                        relu_enable_ff;
   logic [dwc_pkg::SHIFT_W-1:0] output_shift_ff;
   logic                        csr_write;

   dwc_pkg::dwc_cmd_type        cmd;

   // register writes are always taken, a beat per cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_height_ff <= dwc_pkg::DIM_W'(dwc_pkg::MAX_HEIGHT);
         plane_width_ff  <= dwc_pkg::DIM_W'(dwc_pkg::MAX_WIDTH);
         relu_enable_ff  <= 1'b0;
         output_shift_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            dwc_pkg::CSR_PLANE_HEIGHT: begin
               plane_height_ff <= csr_wdata[dwc_pkg::DIM_W-1:0];
            end
            dwc_pkg::CSR_PLANE_WIDTH: begin
               plane_width_ff <= csr_wdata[dwc_pkg::DIM_W-1:0];
            end
            dwc_pkg::CSR_RELU_ENABLE: begin
               relu_enable_ff <= csr_wdata[0];
            end
            dwc_pkg::CSR_OUTPUT_SHIFT: begin
               output_shift_ff <= csr_wdata[dwc_pkg::SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: owns the handshakes and the tap counters
   dwc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   // stores, window addressing and the multiply-accumulate
   dwc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_sample     (req_sample),
      .req_bias_value (req_bias_value),
      .plane_height   (plane_height_ff),
      .plane_width    (plane_width_ff),
      .relu_enable    (relu_enable_ff),
      .output_shift   (output_shift_ff),
      .rsp_out_pixel  (rsp_out_pixel)
   );

endmodule

[hdl/dwc_ram.sv]
// ----------------------------------------------------------------------------
// dwc_ram: generic single-port ram
// one read or write per cycle, registered read data
// ----------------------------------------------------------------------------
module dwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[addr] <= wdata;
      end
      rdata_ff <= ram_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/dwc_ctrl.sv]
// ----------------------------------------------------------------------------
// dwc_ctrl: sequencer for the convolution
// steps through the 49 taps, then shift, saturate and result hand-off
// ----------------------------------------------------------------------------
module dwc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [dwc_pkg::OP_W-1:0]  req_operation,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dwc_pkg::dwc_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam logic [dwc_pkg::KIDX_W-1:0] K_LAST = dwc_pkg::KIDX_W'(dwc_pkg::KSIZE - 1);

   logic [2:0]                   state_ff, state_in;
   logic [dwc_pkg::KIDX_W-1:0]   kr_ff, kr_in;
   logic [dwc_pkg::KIDX_W-1:0]   kc_ff, kc_in;
   logic [dwc_pkg::TAP_W-1:0]    tap_ff, tap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic                         slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      tap_in       = tap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.accept   = accept;
      cmd.kr       = kr_ff;
      cmd.kc       = kc_ff;
      cmd.tap      = tap_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_operation == dwc_pkg::OP_COMPUTE) begin
               cmd.start = 1'b1;
               kr_in     = '0;
               kc_in     = '0;
               tap_in    = '0;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            cmd.issue = 1'b1;
            tap_in    = tap_ff + 1'b1;
            if (kc_ff == K_LAST) begin
               kc_in = '0;
               if (kr_ff == K_LAST) begin
                  state_in = S_DRAIN;
               end else begin
                  kr_in = kr_ff + 1'b1;
               end
            end else begin
               kc_in = kc_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_en = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kr_ff        <= '0;
         kc_ff        <= '0;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kr_ff        <= kr_in;
         kc_ff        <= kc_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/dwc_dp.sv]
// ----------------------------------------------------------------------------
// dwc_dp: convolution datapath
// pixel and weight stores, window addressing, multiply-accumulate, shift and saturate, no rounding
// ----------------------------------------------------------------------------
module dwc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  dwc_pkg::dwc_cmd_type              cmd,
   input  logic [dwc_pkg::OP_W-1:0]          req_operation,
   input  logic [dwc_pkg::ROW_W-1:0]         req_row,
   input  logic [dwc_pkg::COL_W-1:0]         req_col,
   input  logic signed [dwc_pkg::DATA_W-1:0] req_sample,
   input  logic signed [dwc_pkg::ACC_W-1:0]  req_bias_value,
   input  logic [dwc_pkg::DIM_W-1:0]         plane_height,
   input  logic [dwc_pkg::DIM_W-1:0]         plane_width,
   input  logic                              relu_enable,
   input  logic [dwc_pkg::SHIFT_W-1:0]       output_shift,
   output logic signed [dwc_pkg::DATA_W-1:0] rsp_out_pixel
);

   localparam int POS_W = dwc_pkg::ROW_W + 2;

   logic [dwc_pkg::ROW_W-1:0]         qrow_ff;
   logic [dwc_pkg::COL_W-1:0]         qcol_ff;
   logic [dwc_pkg::ACC_W-1:0]         bias_ff;
   logic [dwc_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic signed [dwc_pkg::ACC_W-1:0]  shifted_ff;
   logic signed [dwc_pkg::DATA_W-1:0] out_pixel_ff, out_pixel_in;
   logic                              mac_ff;

   logic [dwc_pkg::DIM_W-1:0]  h_eff, w_eff;
   logic [POS_W-1:0]           r_raw, c_raw;
   logic                       row_ok, col_ok;
   logic [dwc_pkg::ROW_W-1:0]  tap_row;
   logic [dwc_pkg::COL_W-1:0]  tap_col;

   logic                       pix_we, wgt_we;
   logic [dwc_pkg::PIX_AW-1:0] pix_addr;
   logic [dwc_pkg::TAP_W-1:0]  wgt_addr, wgt_waddr;
   logic [dwc_pkg::DATA_W-1:0] pix_rdata, wgt_rdata;
   logic signed [dwc_pkg::PROD_W-1:0] prod;

   // plane size saturates at the store size
   assign h_eff = (plane_height > dwc_pkg::DIM_W'(dwc_pkg::MAX_HEIGHT)) ?
                  dwc_pkg::DIM_W'(dwc_pkg::MAX_HEIGHT) : plane_height;
   assign w_eff = (plane_width > dwc_pkg::DIM_W'(dwc_pkg::MAX_WIDTH)) ?
                  dwc_pkg::DIM_W'(dwc_pkg::MAX_WIDTH) : plane_width;

   // tap position offset by the padding, so it never goes negative
   assign r_raw  = POS_W'(qrow_ff) + POS_W'(cmd.kr);
   assign c_raw  = POS_W'(qcol_ff) + POS_W'(cmd.kc);
   assign row_ok = (r_raw >= POS_W'(dwc_pkg::KPAD)) &&
                   (r_raw < POS_W'(h_eff) + POS_W'(dwc_pkg::KPAD));
   assign col_ok = (c_raw >= POS_W'(dwc_pkg::KPAD)) &&
                   (c_raw < POS_W'(w_eff) + POS_W'(dwc_pkg::KPAD));
   assign tap_row = dwc_pkg::ROW_W'(r_raw - POS_W'(dwc_pkg::KPAD));
   assign tap_col = dwc_pkg::COL_W'(c_raw - POS_W'(dwc_pkg::KPAD));

   // row-major store, the row pitch is a power of two
   assign pix_we   = cmd.accept && (req_operation == dwc_pkg::OP_STORE_PIXEL);
   assign pix_addr = cmd.issue ? {tap_row, tap_col} : {req_row, req_col};

   assign wgt_we    = cmd.accept && (req_operation == dwc_pkg::OP_LOAD_WEIGHT) &&
                      (req_row < dwc_pkg::ROW_W'(dwc_pkg::KSIZE)) &&
                      (req_col < dwc_pkg::COL_W'(dwc_pkg::KSIZE));
   assign wgt_waddr = dwc_pkg::TAP_W'(req_row[dwc_pkg::KIDX_W-1:0]) *
                      dwc_pkg::TAP_W'(dwc_pkg::KSIZE) +
                      dwc_pkg::TAP_W'(req_col[dwc_pkg::KIDX_W-1:0]);
   assign wgt_addr  = cmd.issue ? cmd.tap : wgt_waddr;

   dwc_ram #(
      .WIDTH(dwc_pkg::DATA_W),
      .DEPTH(dwc_pkg::PIX_DEPTH)
   ) u_pix_ram (
      .clock (clock),
      .we    (pix_we),
      .addr  (pix_addr),
      .wdata (req_sample),
      .rdata (pix_rdata)
   );

   dwc_ram #(
      .WIDTH(dwc_pkg::DATA_W),
      .DEPTH(dwc_pkg::KTAPS)
   ) u_wgt_ram (
      .clock (clock),
      .we    (wgt_we),
      .addr  (wgt_addr),
      .wdata (req_sample),
      .rdata (wgt_rdata)
   );

   assign prod = $signed(pix_rdata) * $signed(wgt_rdata);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = bias_ff;
      end else if (mac_ff) begin
         acc_in = acc_ff + dwc_pkg::ACC_W'(prod);
      end
   end

   // saturate, then optional rectify
   always_comb begin
      if (shifted_ff > dwc_pkg::ACC_W'(dwc_pkg::SAT_HI)) begin
         out_pixel_in = dwc_pkg::DATA_W'(dwc_pkg::SAT_HI);
      end else if (shifted_ff < dwc_pkg::ACC_W'(dwc_pkg::SAT_LO)) begin
         out_pixel_in = dwc_pkg::DATA_W'(dwc_pkg::SAT_LO);
      end else begin
         out_pixel_in = shifted_ff[dwc_pkg::DATA_W-1:0];
      end
      if (relu_enable && out_pixel_in[dwc_pkg::DATA_W-1]) begin
         out_pixel_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= 1'b0;
      end else begin
         mac_ff <= cmd.issue && row_ok && col_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qrow_ff <= req_row;
         qcol_ff <= req_col;
      end
      if (cmd.accept && req_operation == dwc_pkg::OP_LOAD_BIAS) begin
         bias_ff <= req_bias_value;
      end
      acc_ff <= acc_in;
      if (cmd.shift_en) begin
         shifted_ff <= $signed(acc_ff) >>> output_shift;
      end
      if (cmd.out_load) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign rsp_out_pixel = out_pixel_ff;

endmodule

[hdl/dwc_checker.sv]
// ----------------------------------------------------------------------------
// dwc_checker: port-level checks for the depthwise convolution
// watches handshakes and result timing, bound to the top level
// ----------------------------------------------------------------------------
module dwc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [dwc_pkg::OP_W-1:0]          req_operation,
   input  logic [dwc_pkg::ROW_W-1:0]         req_row,
   input  logic [dwc_pkg::COL_W-1:0]         req_col,
   input  logic signed [dwc_pkg::DATA_W-1:0] req_sample,
   input  logic signed [dwc_pkg::ACC_W-1:0]  req_bias_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [dwc_pkg::DATA_W-1:0] rsp_out_pixel,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [dwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dwc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   // a result held back keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_pixel))
      else $error("result changed or dropped while stalled");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // loads never produce a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_operation != dwc_pkg::OP_COMPUTE && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a load beat");

   // a compute query occupies the block
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_operation == dwc_pkg::OP_COMPUTE |=> !req_ready)
      else $error("request taken while a query is in progress");

endmodule

bind depthwise_conv7x7_int8 dwc_checker u_dwc_checker (.*);
